>>> rtl/jfs_pkg.sv
// Shared types, codes and helpers for the JPEG frame size scanner.
// Depends on nothing; every other file in rtl/ but jfs_if imports it.
package jfs_pkg;

   // parse phase codes
   localparam logic [3:0] PH_SIG0 = 4'd0;
   localparam logic [3:0] PH_SIG1 = 4'd1;
   localparam logic [3:0] PH_MK0  = 4'd2;
   localparam logic [3:0] PH_DROP = 4'd3;
   localparam logic [3:0] PH_HUNT = 4'd4;
   localparam logic [3:0] PH_MK1  = 4'd5;
   localparam logic [3:0] PH_LEN0 = 4'd6;
   localparam logic [3:0] PH_LEN1 = 4'd7;
   localparam logic [3:0] PH_SOF  = 4'd8;
   localparam logic [3:0] PH_SKIP = 4'd9;

   // result status codes
   localparam logic [2:0] ST_FOUND   = 3'd0;
   localparam logic [2:0] ST_BADSIG  = 3'd1;
   localparam logic [2:0] ST_ENDSCAN = 3'd2;
   localparam logic [2:0] ST_BADLEN  = 3'd3;
   localparam logic [2:0] ST_ENDED   = 3'd4;

   // marker bytes
   localparam logic [7:0] MK_PREFIX = 8'hff;
   localparam logic [7:0] MK_SOI    = 8'hd8;
   localparam logic [7:0] MK_EOI    = 8'hd9;
   localparam logic [7:0] MK_SOS    = 8'hda;
   localparam logic [7:0] MK_SOF_LO = 8'hc0;
   localparam logic [7:0] MK_SOF_HI = 8'hcf;
   localparam logic [7:0] MK_DHT    = 8'hc4;
   localparam logic [7:0] MK_JPG    = 8'hc8;
   localparam logic [7:0] MK_DAC    = 8'hcc;

   // positions inside the frame header
   localparam logic [2:0] FH_HEIGHT_HI = 3'd1;
   localparam logic [2:0] FH_HEIGHT_LO = 3'd2;
   localparam logic [2:0] FH_WIDTH_HI  = 3'd3;
   localparam logic [2:0] FH_WIDTH_LO  = 3'd4;

   typedef struct packed {
      logic [3:0]  phase;
      logic [15:0] skip_remaining;
      logic [7:0]  length_high;
      logic [7:0]  current_marker;
      logic [2:0]  frame_byte_index;
      logic [15:0] height_held;
      logic [7:0]  width_high;
      logic        decided;
   } jfs_state_type;

   localparam jfs_state_type STATE_RESET = '{
      phase:            PH_SIG0,
      skip_remaining:   16'd0,
      length_high:      8'd0,
      current_marker:   8'd0,
      frame_byte_index: 3'd0,
      height_held:      16'd0,
      width_high:       8'd0,
      decided:          1'b0
   };

   typedef struct packed {
      logic [2:0]  status;
      logic [15:0] frame_width;
      logic [15:0] frame_height;
   } jfs_result_type;

   typedef struct packed {
      logic           hit;
      jfs_result_type result;
   } jfs_step_type;

   function automatic logic is_frame_marker(input logic [7:0] m);
      return (m >= MK_SOF_LO) && (m <= MK_SOF_HI) &&
             (m != MK_DHT) && (m != MK_JPG) && (m != MK_DAC);
   endfunction

endpackage

>>> rtl/jfs_if.sv
// Valid/ready channel interfaces for the scanner's byte input and result output.
// Depends on nothing.
interface jfs_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       last_byte;

   modport source (output valid, output data_byte, output last_byte, input ready);
   modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface jfs_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  status;
   logic [15:0] frame_width;
   logic [15:0] frame_height;

   modport source (output valid, output status, output frame_width,
                   output frame_height, input ready);
   modport sink   (input valid, input status, input frame_width,
                   input frame_height, output ready);
endinterface

>>> rtl/jpeg_frame_size_scanner.sv
// Top level of the JPEG frame size scanner: byte input register, parser state,
// result register. Depends on jfs_pkg, jfs_if and jfs_parse_step.
//
// A byte's result goes from the parse step into the result register, then to rsp.
// Throughput: one byte per cycle; the only stall is a held result on rsp.
// Reset: synchronous, active high; clears both valid flags and the parser state.
module jpeg_frame_size_scanner (
   input  logic     clock,
   input  logic     reset,
   jfs_req_if.sink   req,
   jfs_rsp_if.source rsp
);
   import jfs_pkg::*;

   // input register
   logic       in_valid_ff;
   logic [7:0] in_byte_ff;
   logic       in_last_ff;

   // parser state
   jfs_state_type state_ff;
   jfs_state_type state_in;
   jfs_step_type  step;

   // result register
   logic           out_valid_ff;
   logic           out_valid_in;
   jfs_result_type out_ff;

   logic advance;
   logic req_take;

   // Advance the held byte when the result register is free or being drained.
   assign advance  = in_valid_ff && (!out_valid_ff || rsp.ready);
   assign req.ready = !in_valid_ff || advance;
   assign req_take = req.valid && req.ready;

   jfs_parse_step u_step (
      .cur_state (state_ff),
      .data_byte (in_byte_ff),
      .last_byte (in_last_ff),
      .nxt_state (state_in),
      .step      (step)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req.ready) begin
         in_valid_ff <= req.valid;
      end
   end

   // Capture payload on every accept; no reset needed.
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_byte_ff <= req.data_byte;
         in_last_ff <= req.last_byte;
      end
   end

   // Step the parser once per byte that moves out of the input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= STATE_RESET;
      end else if (advance) begin
         state_ff <= state_in;
      end
   end

   // Load a result when the byte produces one, drop it once taken.
   always_comb begin
      out_valid_in = out_valid_ff;
      if (advance && step.hit) begin
         out_valid_in = 1'b1;
      end else if (rsp.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && step.hit) begin
         out_ff <= step.result;
      end
   end

   assign rsp.valid        = out_valid_ff;
   assign rsp.status       = out_ff.status;
   assign rsp.frame_width  = out_ff.frame_width;
   assign rsp.frame_height = out_ff.frame_height;
endmodule

>>> rtl/jfs_parse_step.sv
// Next-state and result logic for one byte of the scanner.
// Depends on jfs_pkg.
module jfs_parse_step (
   input  jfs_pkg::jfs_state_type cur_state,
   input  logic [7:0]             data_byte,
   input  logic                   last_byte,
   output jfs_pkg::jfs_state_type nxt_state,
   output jfs_pkg::jfs_step_type  step
);
   import jfs_pkg::*;

   logic [15:0] seg_len;
   logic [15:0] skip_dec;

   assign seg_len  = {cur_state.length_high, data_byte};
   assign skip_dec = cur_state.skip_remaining - 16'd1;

   always_comb begin
      nxt_state = cur_state;
      step      = '0;

      if (cur_state.decided) begin
         if (last_byte) begin
            nxt_state = STATE_RESET;
         end
      end else begin
         unique case (cur_state.phase)
            PH_SIG0: begin
               if (data_byte != MK_PREFIX) begin
                  step.hit           = 1'b1;
                  step.result.status = ST_BADSIG;
               end else begin
                  nxt_state.phase = PH_SIG1;
               end
            end
            PH_SIG1: begin
               if (data_byte != MK_SOI) begin
                  step.hit           = 1'b1;
                  step.result.status = ST_BADSIG;
               end else begin
                  nxt_state.phase = PH_MK0;
               end
            end
            PH_MK0: begin
               nxt_state.phase = (data_byte == MK_PREFIX) ? PH_MK1 : PH_DROP;
            end
            PH_DROP: begin
               nxt_state.phase = PH_HUNT;
            end
            PH_HUNT: begin
               if (data_byte == MK_PREFIX) begin
                  nxt_state.phase = PH_MK1;
               end
            end
            PH_MK1: begin
               if (data_byte == MK_EOI || data_byte == MK_SOS) begin
                  step.hit           = 1'b1;
                  step.result.status = ST_ENDSCAN;
               end else begin
                  nxt_state.current_marker = data_byte;
                  nxt_state.phase          = PH_LEN0;
               end
            end
            PH_LEN0: begin
               nxt_state.length_high = data_byte;
               nxt_state.phase       = PH_LEN1;
            end
            PH_LEN1: begin
               if (is_frame_marker(cur_state.current_marker)) begin
                  nxt_state.frame_byte_index = 3'd0;
                  nxt_state.phase            = PH_SOF;
               end else if (seg_len[15:1] == 15'd0) begin
                  step.hit           = 1'b1;
                  step.result.status = ST_BADLEN;
               end else begin
                  nxt_state.skip_remaining = seg_len - 16'd2;
                  nxt_state.phase = (seg_len == 16'd2) ? PH_MK0 : PH_SKIP;
               end
            end
            PH_SOF: begin
               unique case (cur_state.frame_byte_index)
                  FH_HEIGHT_HI: nxt_state.height_held = {data_byte, 8'd0};
                  FH_HEIGHT_LO: nxt_state.height_held =
                                   {cur_state.height_held[15:8], data_byte};
                  FH_WIDTH_HI:  nxt_state.width_high = data_byte;
                  FH_WIDTH_LO: begin
                     step.hit                 = 1'b1;
                     step.result.status       = ST_FOUND;
                     step.result.frame_width  = {cur_state.width_high, data_byte};
                     step.result.frame_height = cur_state.height_held;
                  end
                  default: ;
               endcase
               nxt_state.frame_byte_index = cur_state.frame_byte_index + 3'd1;
            end
            PH_SKIP: begin
               nxt_state.skip_remaining = skip_dec;
               if (skip_dec == 16'd0) begin
                  nxt_state.phase = PH_MK0;
               end
            end
            default: begin
               nxt_state.phase = PH_SIG0;
            end
         endcase

         if (step.hit) begin
            nxt_state.decided = 1'b1;
            if (last_byte) begin
               nxt_state = STATE_RESET;
            end
         end else if (last_byte) begin
            step.hit           = 1'b1;
            step.result.status = ST_ENDED;
            nxt_state          = STATE_RESET;
         end
      end
   end
endmodule

>>> rtl/jfs_checker.sv
// Port-level checks for the JPEG frame size scanner, bound to the top level.
// Depends on jfs_pkg and jpeg_frame_size_scanner.
module jfs_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [2:0]  rsp_status,
   input logic [15:0] rsp_frame_width,
   input logic [15:0] rsp_frame_height
);
   import jfs_pkg::*;

   // A stalled result holds its value.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) &&
         $stable(rsp_frame_width) && $stable(rsp_frame_height))
      else $error("stalled result changed");

   // Only the defined status codes leave the block.
   a_status_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status <= ST_ENDED)
      else $error("status code out of range");

   // Size fields are zero unless a frame header was found.
   a_size_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_FOUND |->
         rsp_frame_width == 16'd0 && rsp_frame_height == 16'd0)
      else $error("size reported without a frame header");

   // A fresh result follows an accepted byte.
   a_rsp_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready && !reset, 2))
      else $error("result without an accepted byte");
endmodule

bind jpeg_frame_size_scanner jfs_checker u_jfs_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req.valid),
   .req_ready        (req.ready),
   .rsp_valid        (rsp.valid),
   .rsp_ready        (rsp.ready),
   .rsp_status       (rsp.status),
   .rsp_frame_width  (rsp.frame_width),
   .rsp_frame_height (rsp.frame_height)
);
